// ----- rtl/core/ocp_pkg.sv -----
// shared types, constants and functions of the orbit camera pose block
package ocp_pkg;

  // field and state widths
  localparam int SENS_W    = 16;
  localparam int ZOOM_W    = 12;
  localparam int DIST_W    = 13;
  localparam int PITCH_W   = 16;
  localparam int YAW_W     = 17;
  localparam int DELTA_W   = 16;
  localparam int POS_W     = 24;
  localparam int QW_W      = 15;
  localparam int Q_W       = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  // cordic sizing: angles in degrees Q.16, vectors in Q2.30
  localparam int ATAN_LEN         = 24;
  localparam int STEP_W           = $clog2(ATAN_LEN);
  localparam int ANG_W            = 26;
  localparam int CRD_W            = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_GAIN      = 652032874;
  localparam int ANG_90           = 90 * 65536;
  localparam int ANG_180          = 180 * 65536;
  localparam int ANG_360          = 360 * 65536;

  // state ranges
  localparam int YAW_FULL  = 92160;
  localparam int PITCH_MIN = -1280;
  localparam int PITCH_MAX = 22784;
  localparam int DIST_MIN  = 512;
  localparam int DIST_MAX  = 5120;
  localparam int Q_ONE     = 16384;

  // reset values
  localparam int SENS_RST  = 6554;
  localparam int ZOOM_RST  = 256;
  localparam int DIST_RST  = 1280;
  localparam int PITCH_RST = 5120;
  localparam int YAW_RST   = 0;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_SCROLL = 2'd1,
    OP_UPDATE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS  = 3'd0,
    REG_ZOOM  = 3'd1,
    REG_DIST  = 3'd2,
    REG_PITCH = 3'd3,
    REG_YAW   = 3'd4
  } reg_idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load_in;
    logic              mul_delta;
    logic              move_sum;
    logic              wrap_q;
    logic              wrap_fin;
    logic              zoom_fin;
    logic              crd_start;
    logic              crd_step;
    logic              crd_store;
    logic              mul1;
    logic              rnd1;
    logic              mul2;
    logic              res_load;
    logic              run;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // arctangent of 2^-i in degrees Q.16
  function automatic logic [22:0] atan_deg(input logic [STEP_W-1:0] i);
    logic [22:0] a;
    case (i)
      5'd0:    a = 23'd2949120;
      5'd1:    a = 23'd1740967;
      5'd2:    a = 23'd919879;
      5'd3:    a = 23'd466945;
      5'd4:    a = 23'd234379;
      5'd5:    a = 23'd117304;
      5'd6:    a = 23'd58666;
      5'd7:    a = 23'd29335;
      5'd8:    a = 23'd14668;
      5'd9:    a = 23'd7334;
      5'd10:   a = 23'd3667;
      5'd11:   a = 23'd1833;
      5'd12:   a = 23'd917;
      5'd13:   a = 23'd458;
      5'd14:   a = 23'd229;
      5'd15:   a = 23'd115;
      5'd16:   a = 23'd57;
      5'd17:   a = 23'd29;
      5'd18:   a = 23'd14;
      5'd19:   a = 23'd7;
      5'd20:   a = 23'd4;
      5'd21:   a = 23'd2;
      5'd22:   a = 23'd1;
      default: a = 23'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/ocp_if.sv -----
// request and result channel interfaces of the orbit camera pose block
interface ocp_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic signed [ocp_pkg::DELTA_W-1:0] delta_x;
  logic signed [ocp_pkg::DELTA_W-1:0] delta_y;
  logic                             target_valid;
  logic signed [ocp_pkg::POS_W-1:0] target_x;
  logic signed [ocp_pkg::POS_W-1:0] target_y;
  logic signed [ocp_pkg::POS_W-1:0] target_z;

  modport source (output valid, operation, delta_x, delta_y, target_valid,
                  target_x, target_y, target_z, input ready);
  modport sink (input valid, operation, delta_x, delta_y, target_valid,
                target_x, target_y, target_z, output ready);
endinterface

interface ocp_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [ocp_pkg::POS_W-1:0] camera_x;
  logic signed [ocp_pkg::POS_W-1:0] camera_y;
  logic signed [ocp_pkg::POS_W-1:0] camera_z;
  logic [ocp_pkg::QW_W-1:0]         quat_w;
  logic signed [ocp_pkg::Q_W-1:0]   quat_x;
  logic signed [ocp_pkg::Q_W-1:0]   quat_y;
  logic signed [ocp_pkg::Q_W-1:0]   quat_z;

  modport source (output valid, camera_x, camera_y, camera_z, quat_w, quat_x,
                  quat_y, quat_z, input ready);
  modport sink (input valid, camera_x, camera_y, camera_z, quat_w, quat_x,
                quat_y, quat_z, output ready);
endinterface

// ----- rtl/core/ocp_cordic.sv -----
// one rotation-mode cordic lane, one micro-rotation per cycle while step is high
module ocp_cordic (
  input  logic                                clk,
  input  logic                                start,
  input  logic                                step,
  input  logic [ocp_pkg::STEP_W-1:0]          idx,
  input  logic signed [ocp_pkg::ANG_W-1:0]    angle,
  output logic signed [ocp_pkg::CRD_W-1:0]    sin_val,
  output logic signed [ocp_pkg::CRD_W-1:0]    cos_val
);
  import ocp_pkg::*;

  logic signed [CRD_W-1:0] x, y;
  logic signed [ANG_W-1:0] z;
  logic                    neg;

  logic signed [ANG_W-1:0] a1, z0, atan;
  logic                    n0;
  logic signed [CRD_W-1:0] xs, ys;

  // fold the angle into -90..90 degrees
  always_comb begin
    a1 = (angle >= ANG_W'(ANG_180)) ? angle - ANG_W'(ANG_360) : angle;
    z0 = a1;
    n0 = 1'b0;
    if (a1 > ANG_W'(ANG_90)) begin
      z0 = a1 - ANG_W'(ANG_180);
      n0 = 1'b1;
    end else if (a1 < -ANG_W'(ANG_90)) begin
      z0 = a1 + ANG_W'(ANG_180);
      n0 = 1'b1;
    end
  end

  assign xs   = x >>> idx;
  assign ys   = y >>> idx;
  assign atan = signed'(ANG_W'(atan_deg(idx)));

  // micro-rotation toward zero residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CRD_W'(CORDIC_GAIN);
      y   <= '0;
      z   <= z0;
      neg <= n0;
    end else if (step) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan;
      end
    end
  end

  assign sin_val = neg ? -y : y;
  assign cos_val = neg ? -x : x;

endmodule

// ----- rtl/core/ocp_ctrl.sv -----
// sequencing state machine of the orbit camera pose block
module ocp_ctrl #(
  parameter int CORDIC_STEPS = ocp_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_op,
  input  logic          req_target_valid,
  output logic          req_ready,
  input  logic          rsp_ready,
  output logic          rsp_valid,
  output ocp_pkg::cmd_t cmd
);
  import ocp_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_MV_MUL  = 14'b00000000000010,
    S_MV_SUM  = 14'b00000000000100,
    S_MV_WQ   = 14'b00000000001000,
    S_MV_WFIN = 14'b00000000010000,
    S_ZM_MUL  = 14'b00000000100000,
    S_ZM_FIN  = 14'b00000001000000,
    S_C_LOAD  = 14'b00000010000000,
    S_C_STEP  = 14'b00000100000000,
    S_C_STORE = 14'b00001000000000,
    S_MUL1    = 14'b00010000000000,
    S_RND     = 14'b00100000000000,
    S_MUL2    = 14'b01000000000000,
    S_RES     = 14'b10000000000000
  } state_t;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step;
  logic                run;
  logic                accept, out_free, last_step;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid & req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_op)
            OP_MOVE:   state_next = S_MV_MUL;
            OP_SCROLL: state_next = S_ZM_MUL;
            OP_UPDATE: state_next = req_target_valid ? S_C_LOAD : S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MV_MUL:  state_next = S_MV_SUM;
      S_MV_SUM:  state_next = S_MV_WQ;
      S_MV_WQ:   state_next = S_MV_WFIN;
      S_MV_WFIN: state_next = S_IDLE;
      S_ZM_MUL:  state_next = S_ZM_FIN;
      S_ZM_FIN:  state_next = S_IDLE;
      S_C_LOAD:  state_next = S_C_STEP;
      S_C_STEP:  state_next = last_step ? S_C_STORE : S_C_STEP;
      S_C_STORE: state_next = run ? S_MUL1 : S_C_LOAD;
      S_MUL1:    state_next = S_RND;
      S_RND:     state_next = S_MUL2;
      S_MUL2:    state_next = S_RES;
      S_RES:     state_next = out_free ? S_IDLE : S_RES;
      default:   state_next = S_IDLE;
    endcase
  end

  // state, cordic counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      run       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) run <= 1'b0;
      else if (state == S_C_STORE) run <= 1'b1;
      if (state == S_C_LOAD) step <= '0;
      else if (state == S_C_STEP && !last_step) step <= step + 1'b1;
      if (state == S_RES && out_free) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.load_in   = accept;
    cmd.mul_delta = (state == S_MV_MUL) || (state == S_ZM_MUL);
    cmd.move_sum  = (state == S_MV_SUM);
    cmd.wrap_q    = (state == S_MV_WQ);
    cmd.wrap_fin  = (state == S_MV_WFIN);
    cmd.zoom_fin  = (state == S_ZM_FIN);
    cmd.crd_start = (state == S_C_LOAD);
    cmd.crd_step  = (state == S_C_STEP);
    cmd.crd_store = (state == S_C_STORE);
    cmd.mul1      = (state == S_MUL1);
    cmd.rnd1      = (state == S_RND);
    cmd.mul2      = (state == S_MUL2);
    cmd.res_load  = (state == S_RES) && out_free;
    cmd.run       = run;
    cmd.step      = step;
  end

endmodule

// ----- rtl/core/ocp_dp.sv -----
// state registers, arithmetic and result register of the orbit camera pose block
module ocp_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ocp_pkg::cmd_t                      cmd,
  input  logic                               cfg_wen,
  input  logic [ocp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ocp_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [ocp_pkg::DELTA_W-1:0] delta_x,
  input  logic signed [ocp_pkg::DELTA_W-1:0] delta_y,
  input  logic signed [ocp_pkg::POS_W-1:0]   target_x,
  input  logic signed [ocp_pkg::POS_W-1:0]   target_y,
  input  logic signed [ocp_pkg::POS_W-1:0]   target_z,
  output logic signed [ocp_pkg::POS_W-1:0]   camera_x,
  output logic signed [ocp_pkg::POS_W-1:0]   camera_y,
  output logic signed [ocp_pkg::POS_W-1:0]   camera_z,
  output logic [ocp_pkg::QW_W-1:0]           quat_w,
  output logic signed [ocp_pkg::Q_W-1:0]     quat_x,
  output logic signed [ocp_pkg::Q_W-1:0]     quat_y,
  output logic signed [ocp_pkg::Q_W-1:0]     quat_z
);
  import ocp_pkg::*;

  // round to nearest, halves away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned s);
    logic signed [63:0] half, a;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    a = (-v + half) >>> s;
    return -a;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    if (v > 64'sd8388607) return POS_W'(24'sh7FFFFF);
    if (v < -64'sd8388608) return POS_W'(24'sh800000);
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [17:0] v);
    if (v > 18'(Q_ONE)) return Q_W'(Q_ONE);
    if (v < -18'(Q_ONE)) return -Q_W'(Q_ONE);
    return v[Q_W-1:0];
  endfunction

  // configuration and orbit state
  logic [SENS_W-1:0]         sens;
  logic [ZOOM_W-1:0]         zoom;
  logic [YAW_W-1:0]          yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic [DIST_W-1:0]         distance;

  // latched request
  logic signed [DELTA_W-1:0] dx, dy;
  logic signed [POS_W-1:0]   tx, ty, tz;

  // move and scroll arithmetic
  logic signed [32:0]  p_dx, p_dy;
  logic signed [28:0]  p_zm;
  logic signed [24:0]  ysum;
  logic [7:0]          wq;
  logic [13:0]         w;
  logic [24:0]         wprod;
  logic [14:0]         rr0;
  logic [5:0]          rr;
  logic signed [25:0]  psum;
  logic signed [29:0]  dsum;
  logic signed [PITCH_W-1:0] cfg_pitch;

  // cordic lanes and results
  logic signed [ANG_W-1:0] ang_a, ang_b;
  logic signed [CRD_W-1:0] sin_a, cos_a, sin_b, cos_b;
  logic signed [CRD_W-1:0] sp, cp, sy, cy, sa, ca, sb, cb;
  logic signed [DIST_W:0]  dist_s;

  // pose products
  logic signed [45:0] p_h, p_v;
  logic signed [63:0] p_w, p_x, p_y, p_z;
  logic signed [21:0] h16;
  logic signed [13:0] vy;
  logic               qw_neg;
  logic signed [17:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [53:0] p_ox, p_oz;
  logic signed [63:0] ox, oz;
  logic signed [17:0] fw, fx, fy, fz;

  assign dist_s    = signed'({1'b0, distance});
  assign cfg_pitch = signed'(cfg_data[PITCH_W-1:0]);

  // yaw wrap: split off the low 11 bits, reduce the rest modulo 45
  assign w     = 14'((ysum >>> 11) + 25'sd4140);
  assign wprod = 25'(w) * 25'd1456;
  assign rr0   = 15'(w) - 15'(wq) * 15'd45;
  assign rr    = (rr0 >= 15'd45) ? 6'(rr0 - 15'd45) : 6'(rr0);

  assign psum = 26'(pitch) + 26'(rnd_sh(64'(p_dy), 8));
  assign dsum = signed'({17'b0, distance}) - 30'(p_zm);

  // lane a: pitch, then half of yaw plus 180; lane b: yaw, then minus half pitch
  assign ang_a = cmd.run ? signed'(ANG_W'((18'(yaw) + 18'd46080) * 25'd128))
                         : signed'(ANG_W'(pitch) <<< 8);
  assign ang_b = cmd.run ? -(signed'(ANG_W'(pitch)) <<< 7)
                         : signed'(ANG_W'({yaw, 8'b0}));

  ocp_cordic u_lane_a (
    .clk(clk), .start(cmd.crd_start), .step(cmd.crd_step), .idx(cmd.step),
    .angle(ang_a), .sin_val(sin_a), .cos_val(cos_a)
  );

  ocp_cordic u_lane_b (
    .clk(clk), .start(cmd.crd_start), .step(cmd.crd_step), .idx(cmd.step),
    .angle(ang_b), .sin_val(sin_b), .cos_val(cos_b)
  );

  // orbit state: reset, configuration loads, move and scroll updates
  always_ff @(posedge clk) begin
    if (rst) begin
      sens     <= SENS_W'(SENS_RST);
      zoom     <= ZOOM_W'(ZOOM_RST);
      distance <= DIST_W'(DIST_RST);
      pitch    <= PITCH_W'(PITCH_RST);
      yaw      <= YAW_W'(YAW_RST);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SENS: sens <= cfg_data[SENS_W-1:0];
        REG_ZOOM: zoom <= cfg_data[ZOOM_W-1:0];
        REG_DIST: begin
          if (cfg_data[DIST_W-1:0] < DIST_W'(DIST_MIN)) distance <= DIST_W'(DIST_MIN);
          else if (cfg_data[DIST_W-1:0] > DIST_W'(DIST_MAX)) distance <= DIST_W'(DIST_MAX);
          else distance <= cfg_data[DIST_W-1:0];
        end
        REG_PITCH: begin
          if (cfg_pitch < PITCH_W'(PITCH_MIN)) pitch <= PITCH_W'(PITCH_MIN);
          else if (cfg_pitch > PITCH_W'(PITCH_MAX)) pitch <= PITCH_W'(PITCH_MAX);
          else pitch <= cfg_pitch;
        end
        REG_YAW: begin
          if (cfg_data >= CFG_W'(YAW_FULL)) yaw <= YAW_W'(cfg_data - CFG_W'(YAW_FULL));
          else yaw <= cfg_data;
        end
        default: ;
      endcase
    end else begin
      if (cmd.move_sum) begin
        if (psum < 26'(PITCH_MIN)) pitch <= PITCH_W'(PITCH_MIN);
        else if (psum > 26'(PITCH_MAX)) pitch <= PITCH_W'(PITCH_MAX);
        else pitch <= psum[PITCH_W-1:0];
      end
      if (cmd.wrap_fin) yaw <= {rr, ysum[10:0]};
      if (cmd.zoom_fin) begin
        if (dsum < 30'(DIST_MIN)) distance <= DIST_W'(DIST_MIN);
        else if (dsum > 30'(DIST_MAX)) distance <= DIST_W'(DIST_MAX);
        else distance <= dsum[DIST_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx <= delta_x;
      dy <= delta_y;
      tx <= target_x;
      ty <= target_y;
      tz <= target_z;
    end
    if (cmd.mul_delta) begin
      p_dx <= dx * signed'({1'b0, sens});
      p_dy <= dy * signed'({1'b0, sens});
      p_zm <= dy * signed'({1'b0, zoom});
    end
    if (cmd.move_sum) ysum <= signed'({8'b0, yaw}) - 25'(rnd_sh(64'(p_dx), 8));
    if (cmd.wrap_q) wq <= wprod[23:16];
    if (cmd.crd_store) begin
      if (cmd.run) begin
        sa <= sin_a; ca <= cos_a; sb <= sin_b; cb <= cos_b;
      end else begin
        sp <= sin_a; cp <= cos_a; sy <= sin_b; cy <= cos_b;
      end
    end
    if (cmd.mul1) begin
      p_h <= dist_s * cp;
      p_v <= dist_s * sp;
      p_w <= ca * cb;
      p_x <= ca * sb;
      p_y <= sa * cb;
      p_z <= sa * sb;
    end
    if (cmd.rnd1) begin
      h16    <= 22'(rnd_sh(64'(p_h), 22));
      vy     <= 14'(rnd_sh(64'(p_v), 30));
      qw_neg <= p_w < 0;
      qw_r   <= 18'(rnd_sh(p_w, 46));
      qx_r   <= 18'(rnd_sh(p_x, 46));
      qy_r   <= 18'(rnd_sh(p_y, 46));
      qz_r   <= -18'(rnd_sh(p_z, 46));
    end
    if (cmd.mul2) begin
      p_ox <= h16 * sy;
      p_oz <= h16 * cy;
    end
  end

  // final rounding, w sign fold and saturation
  always_comb begin
    ox = rnd_sh(64'(p_ox), 38);
    oz = rnd_sh(64'(p_oz), 38);
    fw = qw_neg ? -qw_r : qw_r;
    fx = qw_neg ? -qx_r : qx_r;
    fy = qw_neg ? -qy_r : qy_r;
    fz = qw_neg ? -qz_r : qz_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      camera_x <= sat_pos(64'(tx) - ox);
      camera_y <= sat_pos(64'(ty) + 64'(vy));
      camera_z <= sat_pos(64'(tz) - oz);
      if (fw < 0) quat_w <= '0;
      else if (fw > 18'(Q_ONE)) quat_w <= QW_W'(Q_ONE);
      else quat_w <= fw[QW_W-1:0];
      quat_x <= sat_q(fx);
      quat_y <= sat_q(fy);
      quat_z <= sat_q(fz);
    end
  end

endmodule

// ----- rtl/core/orbit_camera_pose.sv -----
// top level of the orbit camera pose block
//
//  channel  dir  handshake           carries
//  req      in   valid / ready       operation, deltas, target position
//  rsp      out  valid / ready       camera position, look-at quaternion
//  cfg      in   cfg_wen             register index and write data
//
// a move steps through multiply, sum, wrap quotient and wrap finish states, a scroll through
// multiply and finish, an update through two cordic rounds, one micro-rotation per cycle in
// each lane, then multiply, round, multiply and result; other transactions leave ready high
// req is ready only between transactions; the result register holds a
// finished pose so the next request is taken while rsp is stalled
// synchronous reset loads the default registers and start pose
module orbit_camera_pose #(
  parameter int CORDIC_STEPS = ocp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ocp_req_if.sink                       req,
  ocp_rsp_if.source                     rsp,
  input  logic                          cfg_wen,
  input  logic [ocp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ocp_pkg::CFG_W-1:0]     cfg_data
);
  import ocp_pkg::*;

  cmd_t cmd;

  ocp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_op(req.operation),
    .req_target_valid(req.target_valid), .req_ready(req.ready),
    .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
    .cmd(cmd)
  );

  ocp_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .delta_x(req.delta_x), .delta_y(req.delta_y),
    .target_x(req.target_x), .target_y(req.target_y), .target_z(req.target_z),
    .camera_x(rsp.camera_x), .camera_y(rsp.camera_y), .camera_z(rsp.camera_z),
    .quat_w(rsp.quat_w), .quat_x(rsp.quat_x), .quat_y(rsp.quat_y),
    .quat_z(rsp.quat_z)
  );

endmodule

// ----- rtl/core/ocp_checker.sv -----
// port-level checks of the orbit camera pose block and their binding
module ocp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic [1:0]                       req_operation,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic signed [ocp_pkg::POS_W-1:0] camera_x,
  input logic [ocp_pkg::QW_W-1:0]         quat_w,
  input logic signed [ocp_pkg::Q_W-1:0]   quat_x,
  input logic signed [ocp_pkg::Q_W-1:0]   quat_y,
  input logic signed [ocp_pkg::Q_W-1:0]   quat_z
);
  import ocp_pkg::*;

  // a stalled result transaction stays
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(camera_x) && $stable(quat_w))
    else $error("result changed while stalled");

  // a move keeps the block busy for the next cycle
  a_move_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_operation == OP_MOVE |=> !req_ready)
    else $error("ready right after a move");

  // quaternion stays normalized range
  a_qw_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> quat_w <= QW_W'(Q_ONE))
    else $error("quat_w out of range");

  a_qv_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> quat_x <= Q_W'(Q_ONE) && quat_x >= -Q_W'(Q_ONE) &&
                  quat_y <= Q_W'(Q_ONE) && quat_y >= -Q_W'(Q_ONE) &&
                  quat_z <= Q_W'(Q_ONE) && quat_z >= -Q_W'(Q_ONE))
    else $error("quaternion vector part out of range");

endmodule

bind orbit_camera_pose ocp_checker u_ocp_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready), .req_operation(req.operation),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .camera_x(rsp.camera_x), .quat_w(rsp.quat_w),
  .quat_x(rsp.quat_x), .quat_y(rsp.quat_y), .quat_z(rsp.quat_z)
);

// ----- dv/tb.sv -----
// self-checking testbench of the orbit camera pose block
`timescale 1ns / 100ps

module tb;
  import ocp_pkg::*;

  localparam int STEPS     = CORDIC_STEPS_DEF;
  localparam int SETTLE    = 60;
  localparam int STALL_MAX = 20000;

  typedef struct {
    logic signed [POS_W-1:0] cam_x;
    logic signed [POS_W-1:0] cam_y;
    logic signed [POS_W-1:0] cam_z;
    logic [QW_W-1:0]         q_w;
    logic signed [Q_W-1:0]   q_x;
    logic signed [Q_W-1:0]   q_y;
    logic signed [Q_W-1:0]   q_z;
  } pose_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ocp_req_if req ();
  ocp_rsp_if rsp ();

  orbit_camera_pose u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req.sink),
    .rsp       (rsp.source),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model copy of registers and orbit state
  longint sens, zoom, yaw, pitch, distance;
  pose_t pose_q[$];
  int errors, n_items, n_poses;
  bit src_idle, snk_stall;
  int stall_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round to nearest, halves away from zero
  function automatic longint round_sh(longint v, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint wrap360(longint v);
    longint r;
    r = v % YAW_FULL;
    return r < 0 ? r + YAW_FULL : r;
  endfunction

  // sine and cosine in Q2.30 of an angle in degrees Q.16
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint full, x, y, z, t, xs, ys;
    bit neg;
    full = longint'(ANG_360);
    x = longint'(CORDIC_GAIN);
    y = 0;
    neg = 0;
    ang = ang % full;
    if (ang < 0) ang += full;
    if (ang >= ANG_180) ang -= full;
    if (ang > ANG_90) begin
      ang -= ANG_180;
      neg = 1;
    end else if (ang < -longint'(ANG_90)) begin
      ang += ANG_180;
      neg = 1;
    end
    z = ang;
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        t = x - ys; y = y + xs; z -= longint'(atan_deg(STEP_W'(i)));
      end else begin
        t = x + ys; y = y - xs; z += longint'(atan_deg(STEP_W'(i)));
      end
      x = t;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endtask

  task automatic model_reset();
    sens     = longint'(SENS_RST);
    zoom     = longint'(ZOOM_RST);
    yaw      = longint'(YAW_RST);
    pitch    = longint'(PITCH_RST);
    distance = longint'(DIST_RST);
  endtask

  task automatic model_write(reg_idx_t idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_SENS:  sens = longint'(d[15:0]);
      REG_ZOOM:  zoom = longint'(d[11:0]);
      REG_DIST:  distance = clampl(longint'(d[12:0]), DIST_MIN, DIST_MAX);
      REG_PITCH: pitch = clampl(longint'($signed(d[15:0])), PITCH_MIN, PITCH_MAX);
      REG_YAW:   yaw = wrap360(longint'(d[16:0]));
      default: ;
    endcase
  endtask

  // advance the orbit state for one request and queue the pose it yields
  task automatic orbit_step(logic [1:0] op, logic signed [DELTA_W-1:0] dx,
                            logic signed [DELTA_W-1:0] dy, logic tv,
                            logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                            logic signed [POS_W-1:0] tz);
    longint sp, cp, sy, cy, sa, ca, sb, cb, h16, ox, oz, vy, qw, qx, qy, qz, lo, hi;
    pose_t p;
    lo = -(longint'(1) <<< 23);
    hi = (longint'(1) <<< 23) - 1;
    if (op == OP_MOVE) begin
      yaw = wrap360(yaw - round_sh(longint'(dx) * sens, 8));
      pitch = clampl(pitch + round_sh(longint'(dy) * sens, 8), PITCH_MIN, PITCH_MAX);
    end else if (op == OP_SCROLL) begin
      distance = clampl(distance - longint'(dy) * zoom, DIST_MIN, DIST_MAX);
    end else if (op == OP_UPDATE && tv) begin
      sin_cos(pitch * 256, sp, cp);
      sin_cos(yaw * 256, sy, cy);
      h16 = round_sh(distance * cp, 22);
      vy = round_sh(distance * sp, 30);
      ox = round_sh(h16 * sy, 38);
      oz = round_sh(h16 * cy, 38);
      p.cam_x = POS_W'(clampl(longint'(tx) - ox, lo, hi));
      p.cam_y = POS_W'(clampl(longint'(ty) + vy, lo, hi));
      p.cam_z = POS_W'(clampl(longint'(tz) - oz, lo, hi));
      sin_cos((yaw + 180 * 256) * 128, sa, ca);
      sin_cos(-pitch * 128, sb, cb);
      qw = ca * cb;
      qx = ca * sb;
      qy = sa * cb;
      qz = -(sa * sb);
      // flip to the hemisphere with non-negative w
      if (qw < 0) begin
        qw = -qw; qx = -qx; qy = -qy; qz = -qz;
      end
      p.q_w = QW_W'(clampl(round_sh(qw, 46), 0, Q_ONE));
      p.q_x = Q_W'(clampl(round_sh(qx, 46), -Q_ONE, Q_ONE));
      p.q_y = Q_W'(clampl(round_sh(qy, 46), -Q_ONE, Q_ONE));
      p.q_z = Q_W'(clampl(round_sh(qz, 46), -Q_ONE, Q_ONE));
      pose_q.push_back(p);
    end
  endtask

  // one request transaction; valid stays high between back-to-back items
  task automatic send_req(logic [1:0] op, logic signed [DELTA_W-1:0] dx,
                          logic signed [DELTA_W-1:0] dy, logic tv,
                          logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                          logic signed [POS_W-1:0] tz);
    if (src_idle && $urandom_range(99) < 70) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.operation    <= op;
    req.delta_x      <= dx;
    req.delta_y      <= dy;
    req.target_valid <= tv;
    req.target_x     <= tx;
    req.target_y     <= ty;
    req.target_z     <= tz;
    do @(posedge clk); while (!req.ready);
    orbit_step(op, dx, dy, tv, tx, ty, tz);
    n_items++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register writes wait until no request is in flight
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
    req.valid <= 1'b0;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_wen <= 1'b0;
    model_write(idx, d);
  endtask

  task automatic update_at(logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                           logic signed [POS_W-1:0] tz);
    send_req(OP_UPDATE, 0, 0, 1'b1, tx, ty, tz);
  endtask

  task automatic rand_item();
    int sel;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [POS_W-1:0] tx, ty, tz;
    sel = $urandom_range(99);
    dx = $urandom_range(3) == 0 ? DELTA_W'($urandom) : DELTA_W'($urandom_range(128) - 64);
    dy = $urandom_range(3) == 0 ? DELTA_W'($urandom) : DELTA_W'($urandom_range(128) - 64);
    if ($urandom_range(1)) begin
      tx = POS_W'($urandom); ty = POS_W'($urandom); tz = POS_W'($urandom);
    end else begin
      tx = POS_W'($urandom_range(8192) - 4096);
      ty = POS_W'($urandom_range(8192) - 4096);
      tz = POS_W'($urandom_range(8192) - 4096);
    end
    if (sel < 40)      send_req(OP_MOVE, dx, dy, 1'($urandom), tx, ty, tz);
    else if (sel < 55) send_req(OP_SCROLL, dx, dy, 1'($urandom), tx, ty, tz);
    else if (sel < 95) send_req(OP_UPDATE, dx, dy, $urandom_range(9) != 0, tx, ty, tz);
    else               send_req(OP_UNUSED, dx, dy, 1'($urandom), tx, ty, tz);
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    rsp.ready <= snk_stall ? ($urandom_range(99) >= 70) : 1'b1;
  end

  // compare every pose transaction with the oldest prediction
  always @(posedge clk) begin
    pose_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose x=%0d y=%0d z=%0d", $time, rsp.camera_x,
                 rsp.camera_y, rsp.camera_z);
        errors++;
      end else begin
        e = pose_q.pop_front();
        n_poses++;
        if (rsp.camera_x !== e.cam_x || rsp.camera_y !== e.cam_y ||
            rsp.camera_z !== e.cam_z) begin
          $display("%0t: camera exp %0d %0d %0d got %0d %0d %0d", $time, e.cam_x,
                   e.cam_y, e.cam_z, rsp.camera_x, rsp.camera_y, rsp.camera_z);
          errors++;
        end
        if (rsp.quat_w !== e.q_w || rsp.quat_x !== e.q_x || rsp.quat_y !== e.q_y ||
            rsp.quat_z !== e.q_z) begin
          $display("%0t: quat exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time, e.q_w,
                   e.q_x, e.q_y, e.q_z, rsp.quat_w, rsp.quat_x, rsp.quat_y, rsp.quat_z);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_wen)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("orbit_camera_pose verification failed");
      $finish;
    end
  end

  task automatic test_reset_pose();
    update_at(0, 0, 0);
    update_at(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    update_at(-24'sh800000, -24'sh800000, -24'sh800000);
    drain();
  endtask

  task automatic test_directed();
    // pitch clamps at both ends, yaw wraps both ways
    send_req(OP_MOVE, 0, 16'sh7fff, 0, 0, 0, 0);
    update_at(100, 200, 300);
    send_req(OP_MOVE, 16'sh7fff, -16'sh8000, 1, 0, 0, 0);
    update_at(-100, 5, 7);
    send_req(OP_MOVE, -16'sh8000, 0, 0, 0, 0, 0);
    update_at(0, 0, 0);
    // distance clamps
    send_req(OP_SCROLL, 0, 16'sh7fff, 0, 0, 0, 0);
    update_at(0, 0, 0);
    send_req(OP_SCROLL, 0, -16'sh8000, 0, 0, 0, 0);
    update_at(0, 0, 0);
    // no result without a target or for the unused code
    send_req(OP_UPDATE, 5, 5, 1'b0, 1, 2, 3);
    send_req(OP_UNUSED, -1, -1, 1'b1, -1, -1, -1);
    // w negative before the flip: yaw at 180 degrees with zero pitch
    write_reg(REG_PITCH, 0);
    write_reg(REG_YAW, 180 * 256);
    update_at(24'sh7fffff, 0, -24'sh800000);
    drain();
  endtask

  task automatic test_config_extremes();
    // out-of-range start values and unknown register indexes
    write_reg(REG_DIST, 0);
    write_reg(REG_PITCH, 17'h08000);
    write_reg(REG_YAW, 17'h1ffff);
    write_reg(reg_idx_t'(5), 17'h1ffff);
    write_reg(reg_idx_t'(7), 17'h1ffff);
    update_at(1, 1, 1);
    drain();
    write_reg(REG_DIST, 17'h1fff);
    write_reg(REG_PITCH, 17'h07fff);
    write_reg(REG_YAW, CFG_W'(YAW_FULL - 1));
    write_reg(REG_SENS, 17'hffff);
    write_reg(REG_ZOOM, 17'hfff);
    send_req(OP_MOVE, 1, -1, 0, 0, 0, 0);
    send_req(OP_SCROLL, 0, 1, 0, 0, 0, 0);
    update_at(0, 0, 0);
    write_reg(REG_SENS, 0);
    write_reg(REG_ZOOM, 0);
    send_req(OP_MOVE, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    send_req(OP_SCROLL, 0, -16'sh8000, 0, 0, 0, 0);
    update_at(0, 0, 0);
    drain();
  endtask

  task automatic random_config();
    write_reg(REG_SENS, $urandom_range(3) == 0 ? CFG_W'($urandom_range(65535))
                                                : CFG_W'($urandom_range(20000)));
    write_reg(REG_ZOOM, CFG_W'($urandom_range(4095)));
    write_reg(REG_DIST, CFG_W'($urandom_range(8191)));
    write_reg(REG_PITCH, CFG_W'($urandom_range(65535)));
    write_reg(REG_YAW, CFG_W'($urandom_range(131071)));
  endtask

  task automatic test_random_phase(bit idle_src, bit stall_snk, int count);
    src_idle  = idle_src;
    snk_stall = stall_snk;
    random_config();
    for (int i = 0; i < count; i++) rand_item();
    drain();
  endtask

  task automatic test_pressure();
    // sender sends batches of 20 items and holds off until every pose has come back
    for (int i = 0; i < 20; i++) rand_item();
    drain();
    for (int i = 0; i < 20; i++) rand_item();
    drain();
  endtask

  initial begin
    errors = 0;
    n_items = 0;
    n_poses = 0;
    src_idle = 0;
    snk_stall = 0;
    model_reset();
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= REG_SENS;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.operation <= OP_MOVE;
    req.delta_x <= '0;
    req.delta_y <= '0;
    req.target_valid <= 1'b0;
    req.target_x <= '0;
    req.target_y <= '0;
    req.target_z <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_pose();
    test_directed();
    test_config_extremes();
    test_random_phase(1'b0, 1'b0, 430);
    test_random_phase(1'b1, 1'b0, 430);
    test_random_phase(1'b0, 1'b1, 430);
    test_random_phase(1'b1, 1'b1, 430);
    test_pressure();

    $display("covered %0d requests and %0d poses over directed corners,", n_items, n_poses);
    $display("register extremes and four handshake pacing phases");
    if (errors == 0 && pose_q.size() == 0) begin
      $display("orbit_camera_pose verification clean");
    end else begin
      $display("orbit_camera_pose verification failed");
    end
    $finish;
  end

endmodule
